// File: src/bpdc_pkg.sv
// Shared types and constants for the button press debounce classifier.
// Used by the front end, the event queue, the back end and the top level.
// No dependencies.
`default_nettype none

package bpdc_pkg;

    // Output fields are fixed at 32 bits.
    localparam int DATA_WIDTH = 32;
    localparam int CNT_WIDTH  = 8;

    // Configuration port.
    localparam int CFG_INDEX_WIDTH = 4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_COUNT = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHORT_LIMIT    = 4'd1;

    localparam logic [CNT_WIDTH-1:0]  DEBOUNCE_RESET    = 8'd5;
    localparam logic [DATA_WIDTH-1:0] SHORT_LIMIT_RESET = 32'd500;

    // Event queue between the front and back ends.
    localparam int QUEUE_DEPTH       = 4;
    localparam int QUEUE_PTR_WIDTH   = 2;
    localparam int QUEUE_COUNT_WIDTH = 3;

    // One confirmed release, as classified by the front end.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] duration;
        logic                  is_short;
    } press_event_t;

endpackage : bpdc_pkg

`default_nettype wire

// File: src/bpdc_front.sv
// Front end: configuration registers, debounce counter, press timestamp and
// duration classification. Depends on bpdc_pkg.
`default_nettype none

module bpdc_front
    import bpdc_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       button_level,
    input  wire logic [DATA_WIDTH-1:0]      now_ms,
    input  wire logic                       cfg_valid,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [DATA_WIDTH-1:0]      cfg_data,
    input  wire logic                       queue_full,
    output logic                            ev_valid,
    output press_event_t                    ev
);

    logic [CNT_WIDTH-1:0]  debounce_reg, debounce_next;
    logic [DATA_WIDTH-1:0] limit_reg, limit_next;
    logic                  stable_reg, stable_next;
    logic [CNT_WIDTH-1:0]  disagree_reg, disagree_next;
    logic [TIME_WIDTH-1:0] start_reg, start_next;

    logic                  accept;
    logic                  raw_pressed;
    logic                  disagree;
    logic [CNT_WIDTH-1:0]  cnt_inc;
    logic                  flip;
    logic [TIME_WIDTH-1:0] now_tw;
    logic [TIME_WIDTH-1:0] diff_tw;
    logic [DATA_WIDTH-1:0] dur32;
    logic                  dur_short;

    assign in_ready = ~queue_full;
    assign accept   = in_valid & in_ready;

    // Bring the timestamp into the internal time width and back out.
    // The class is decided on the full-width difference.
    generate
        if (TIME_WIDTH >= DATA_WIDTH) begin : g_wide_time
            assign now_tw    = TIME_WIDTH'(now_ms);
            assign dur32     = diff_tw[DATA_WIDTH-1:0];
            assign dur_short = diff_tw < TIME_WIDTH'(limit_reg);
        end else begin : g_narrow_time
            assign now_tw    = now_ms[TIME_WIDTH-1:0];
            assign dur32     = {{(DATA_WIDTH-TIME_WIDTH){1'b0}}, diff_tw};
            assign dur_short = dur32 < limit_reg;
        end
    endgenerate

    // Debounce decision for the current sample.
    assign raw_pressed = ~button_level;
    assign disagree    = raw_pressed != stable_reg;
    assign cnt_inc     = disagree_reg + CNT_WIDTH'(1);
    assign flip        = disagree & ~(cnt_inc < debounce_reg);

    // Duration and class of a release; a wrapped timestamp wraps the difference.
    assign diff_tw     = now_tw - start_reg;
    assign ev.duration = dur32;
    assign ev.is_short = dur_short;
    assign ev_valid    = accept & flip & ~raw_pressed;

    // Configuration writes; unknown indexes are ignored.
    always_comb begin
        debounce_next = debounce_reg;
        limit_next    = limit_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEBOUNCE_COUNT: debounce_next = cfg_data[CNT_WIDTH-1:0];
                REG_SHORT_LIMIT:    limit_next    = cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Debounce state update for each accepted item.
    always_comb begin
        stable_next   = stable_reg;
        disagree_next = disagree_reg;
        start_next    = start_reg;
        if (accept) begin
            if (!disagree) begin
                disagree_next = '0;
            end else if (flip) begin
                disagree_next = '0;
                stable_next   = raw_pressed;
                if (raw_pressed) begin
                    start_next = now_tw;
                end
            end else begin
                disagree_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            limit_reg    <= SHORT_LIMIT_RESET;
            stable_reg   <= 1'b0;
            disagree_reg <= '0;
            start_reg    <= '0;
        end else begin
            debounce_reg <= debounce_next;
            limit_reg    <= limit_next;
            stable_reg   <= stable_next;
            disagree_reg <= disagree_next;
            start_reg    <= start_next;
        end
    end

endmodule : bpdc_front

`default_nettype wire

// File: src/bpdc_queue.sv
// Short event queue between the front and back ends, with push and pop in
// the same cycle. Depends on bpdc_pkg.
`default_nettype none

module bpdc_queue
    import bpdc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push_valid,
    input  wire press_event_t push_data,
    output logic              full,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output press_event_t      pop_data
);

    press_event_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_COUNT_WIDTH-1:0] count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign full      = count_reg == QUEUE_COUNT_WIDTH'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = mem[rd_ptr_reg];
    assign do_push   = push_valid & ~full;
    assign do_pop    = pop_valid & pop_ready;

    // Pointer and fill count update; the depth is a power of two.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + QUEUE_PTR_WIDTH'(1);
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + QUEUE_PTR_WIDTH'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QUEUE_COUNT_WIDTH'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - QUEUE_COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for queued events.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule : bpdc_queue

`default_nettype wire

// File: src/bpdc_back.sv
// Back end: running totals and the output register of the result channel.
// Depends on bpdc_pkg.
`default_nettype none

module bpdc_back
    import bpdc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               ev_valid,
    output logic                    ev_ready,
    input  wire press_event_t       ev,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [DATA_WIDTH-1:0]   duration_ms,
    output logic                    is_short,
    output logic [DATA_WIDTH-1:0]   event_number,
    output logic [DATA_WIDTH-1:0]   press_total,
    output logic [DATA_WIDTH-1:0]   short_total,
    output logic [DATA_WIDTH-1:0]   long_total,
    output logic [DATA_WIDTH-1:0]   time_total,
    output logic [DATA_WIDTH-1:0]   short_time_total,
    output logic [DATA_WIDTH-1:0]   long_time_total
);

    logic                  valid_reg;
    logic [DATA_WIDTH-1:0] dur_reg;
    logic                  short_reg;
    // The event index and the count of all presses always move together.
    logic [DATA_WIDTH-1:0] all_count_reg, all_count_next;
    logic [DATA_WIDTH-1:0] short_count_reg, short_count_next;
    logic [DATA_WIDTH-1:0] long_count_reg, long_count_next;
    logic [DATA_WIDTH-1:0] all_time_reg, all_time_next;
    logic [DATA_WIDTH-1:0] short_time_reg, short_time_next;
    logic [DATA_WIDTH-1:0] long_time_reg, long_time_next;
    logic                  take;

    // A new event is taken when the output register is empty or being drained.
    assign ev_ready = ~valid_reg | out_ready;
    assign take     = ev_valid & ev_ready;

    // Totals after the event; they also form the result payload.
    always_comb begin
        all_count_next   = all_count_reg;
        short_count_next = short_count_reg;
        long_count_next  = long_count_reg;
        all_time_next    = all_time_reg;
        short_time_next  = short_time_reg;
        long_time_next   = long_time_reg;
        if (take) begin
            all_count_next = all_count_reg + DATA_WIDTH'(1);
            all_time_next  = all_time_reg + ev.duration;
            if (ev.is_short) begin
                short_count_next = short_count_reg + DATA_WIDTH'(1);
                short_time_next  = short_time_reg + ev.duration;
            end else begin
                long_count_next = long_count_reg + DATA_WIDTH'(1);
                long_time_next  = long_time_reg + ev.duration;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            all_count_reg   <= '0;
            short_count_reg <= '0;
            long_count_reg  <= '0;
            all_time_reg    <= '0;
            short_time_reg  <= '0;
            long_time_reg   <= '0;
        end else begin
            if (take) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
            all_count_reg   <= all_count_next;
            short_count_reg <= short_count_next;
            long_count_reg  <= long_count_next;
            all_time_reg    <= all_time_next;
            short_time_reg  <= short_time_next;
            long_time_reg   <= long_time_next;
        end
    end

    // Per-event payload of the output register.
    always_ff @(posedge aclk) begin
        if (take) begin
            dur_reg   <= ev.duration;
            short_reg <= ev.is_short;
        end
    end

    assign out_valid        = valid_reg;
    assign duration_ms      = dur_reg;
    assign is_short         = short_reg;
    assign event_number     = all_count_reg;
    assign press_total      = all_count_reg;
    assign short_total      = short_count_reg;
    assign long_total       = long_count_reg;
    assign time_total       = all_time_reg;
    assign short_time_total = short_time_reg;
    assign long_time_total  = long_time_reg;

endmodule : bpdc_back

`default_nettype wire

// File: src/button_press_debounce_classifier.sv
// Button press debounce classifier, top level. Instantiates bpdc_front,
// bpdc_queue and bpdc_back; depends on bpdc_pkg.
// Throughput: one sample item per cycle while the four-entry event queue has
// room; the back end drains one event a cycle unless its output is stalled.
// A release result is held in the event queue, then in the output register.
// Reset (synchronous, aresetn low): totals, debounce state and queue cleared,
// debounce count set to 5 and short limit to 500 ms.
`default_nettype none

module button_press_debounce_classifier
    import bpdc_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // s_tdata: [0] button_level, [32:1] now_ms, [39:33] zero
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [39:0]                s_tdata,
    // m_tdata: [31:0] duration_ms, [63:32] event_number, [95:64] press_total,
    // [127:96] short_total, [159:128] long_total, [191:160] time_total,
    // [223:192] short_time_total, [255:224] long_time_total
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [255:0]                    m_tdata,
    // m_tuser: [0] is_short
    output logic [0:0]                      m_tuser,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [DATA_WIDTH-1:0]      cfg_data
);

    logic                  front_ev_valid;
    press_event_t          front_ev;
    logic                  queue_full;
    logic                  queue_valid;
    logic                  queue_ready;
    press_event_t          queue_ev;
    logic [DATA_WIDTH-1:0] duration_ms;
    logic                  is_short;
    logic [DATA_WIDTH-1:0] event_number;
    logic [DATA_WIDTH-1:0] press_total;
    logic [DATA_WIDTH-1:0] short_total;
    logic [DATA_WIDTH-1:0] long_total;
    logic [DATA_WIDTH-1:0] time_total;
    logic [DATA_WIDTH-1:0] short_time_total;
    logic [DATA_WIDTH-1:0] long_time_total;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    bpdc_front #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .button_level(s_tdata[0]),
        .now_ms      (s_tdata[32:1]),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_full  (queue_full),
        .ev_valid    (front_ev_valid),
        .ev          (front_ev)
    );

    bpdc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(front_ev_valid),
        .push_data (front_ev),
        .full      (queue_full),
        .pop_valid (queue_valid),
        .pop_ready (queue_ready),
        .pop_data  (queue_ev)
    );

    bpdc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ev_valid        (queue_valid),
        .ev_ready        (queue_ready),
        .ev              (queue_ev),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .duration_ms     (duration_ms),
        .is_short        (is_short),
        .event_number    (event_number),
        .press_total     (press_total),
        .short_total     (short_total),
        .long_total      (long_total),
        .time_total      (time_total),
        .short_time_total(short_time_total),
        .long_time_total (long_time_total)
    );

    // Pack the result item onto the master side.
    assign m_tdata = {long_time_total, short_time_total, time_total, long_total,
                      short_total, press_total, event_number, duration_ms};
    assign m_tuser = is_short;

endmodule : button_press_debounce_classifier

`default_nettype wire
